>>> sv/ictf_pkg.sv
// shared types, constants and helpers of the tilt complementary filter
package ictf_pkg;

    // angles inside the block are degrees * 2^16
    localparam logic signed [27:0] DEG180 = 28'sd11796480;
    localparam logic signed [26:0] DEG90  = 27'sd5898240;

    // blend divider operand widths
    localparam int unsigned DIV_NW = 52;
    localparam int unsigned DIV_DW = 27;
    localparam logic [9:0]  US_PER_MS = 10'd1000;

    // gyro increment |rate*dt| * 2^16 / (131 * 1e6), rounded, reduced by 64 to
    // (n * 1024 + 1023437) / 2046875; reciprocal estimate plus remainder fix
    localparam logic [20:0] INC_D     = 21'd2046875;
    localparam logic [21:0] INC_D2    = 22'd4093750;
    localparam logic [19:0] INC_RND   = 20'd1023437;
    localparam logic [31:0] INC_RECIP = 32'((64'd1 << 52) / 64'd2046875);

    localparam int unsigned TABLE_LEN = 24;

    typedef struct packed {
        logic [13:0]        tau_ms;
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
    } cfg_t;

    typedef struct packed {
        logic               zero;
        logic signed [27:0] x;
        logic signed [27:0] y;
        logic signed [26:0] z;
    } cordic_init_t;

    typedef struct packed {
        cordic_init_t       ax;
        cordic_init_t       ay;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [15:0]        dt;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // arctangent of 2^-i in degrees * 2^16, rounded to nearest
    function automatic logic signed [26:0] atan_q16(input logic [4:0] i);
        logic signed [26:0] r;
        unique case (i)
            5'd0:  r = 27'sd2949120;
            5'd1:  r = 27'sd1740967;
            5'd2:  r = 27'sd919879;
            5'd3:  r = 27'sd466945;
            5'd4:  r = 27'sd234379;
            5'd5:  r = 27'sd117304;
            5'd6:  r = 27'sd58666;
            5'd7:  r = 27'sd29335;
            5'd8:  r = 27'sd14668;
            5'd9:  r = 27'sd7334;
            5'd10: r = 27'sd3667;
            5'd11: r = 27'sd1833;
            5'd12: r = 27'sd917;
            5'd13: r = 27'sd458;
            5'd14: r = 27'sd229;
            5'd15: r = 27'sd115;
            5'd16: r = 27'sd57;
            5'd17: r = 27'sd29;
            5'd18: r = 27'sd14;
            5'd19: r = 27'sd7;
            5'd20: r = 27'sd4;
            5'd21: r = 27'sd2;
            5'd22: r = 27'sd1;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

    // saturate to +-180 degrees
    function automatic logic signed [24:0] clamp180(input logic signed [27:0] v);
        logic signed [24:0] r;
        if (v > DEG180)
            r = 25'(DEG180);
        else if (v < -DEG180)
            r = 25'(-DEG180);
        else
            r = 25'(v);
        return r;
    endfunction

endpackage

>>> sv/ictf_front.sv
// front end: unpacks an input transaction and sets up both cordic vectors
module ictf_front (
    input  logic [95:0]    tdata,
    output ictf_pkg::item_t item
);
    import ictf_pkg::*;

    // quadrant pre-rotation so the vector lands in the right half plane
    function automatic cordic_init_t prerot(input logic signed [16:0] yv,
                                            input logic signed [16:0] xv);
        cordic_init_t       r;
        logic signed [27:0] xs;
        logic signed [27:0] ys;
        xs = 28'(xv) <<< 8;
        ys = 28'(yv) <<< 8;
        r.zero = (xv == 17'sd0) && (yv == 17'sd0);
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                r.z = DEG90;
                r.x = ys;
                r.y = -xs;
            end
            else
            begin
                r.z = -DEG90;
                r.x = -ys;
                r.y = xs;
            end
        end
        else
        begin
            r.z = 27'sd0;
            r.x = xs;
            r.y = ys;
        end
        return r;
    endfunction

    logic signed [16:0] ax_w;
    logic signed [16:0] ay_w;
    logic signed [16:0] az_w;
    logic signed [16:0] nax_w;

    assign ax_w  = 17'($signed(tdata[15:0]));
    assign ay_w  = 17'($signed(tdata[31:16]));
    assign az_w  = 17'($signed(tdata[47:32]));
    assign nax_w = -ax_w;

    // x tilt is atan2(ay, az), y tilt is atan2(-ax, az)
    assign item.ax = prerot(ay_w, az_w);
    assign item.ay = prerot(nax_w, az_w);
    assign item.gx = $signed(tdata[63:48]);
    assign item.gy = $signed(tdata[79:64]);
    assign item.dt = tdata[95:80];

endmodule

>>> sv/ictf_queue.sv
// two-entry queue between the front end and the filter engine
module ictf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ictf_pkg::item_t   push_item,
    input  logic              pop,
    output ictf_pkg::item_t   pop_item,
    output ictf_pkg::q_stat_t stat
);
    import ictf_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_item;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign pop_item   = mem_reg[rptr_reg];
    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);

endmodule

>>> sv/ictf_div.sv
// restoring divider, one quotient bit per cycle
module ictf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ictf_pkg::DIV_NW-1:0]   num,
    input  logic [ictf_pkg::DIV_DW-1:0]   den,
    output logic                          done,
    output logic [ictf_pkg::DIV_NW-1:0]   quo
);
    import ictf_pkg::*;

    logic [DIV_NW-1:0] nq_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rsh;
    logic              qbit;
    logic [DIV_DW-1:0] rem_next;

    // one trial subtraction
    always_comb
    begin
        rsh  = {rem_reg, nq_reg[DIV_NW-1]};
        qbit = (rsh >= {1'b0, den_reg});
        if (qbit)
            rem_next = DIV_DW'(rsh - {1'b0, den_reg});
        else
            rem_next = DIV_DW'(rsh);
    end

    // operands and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[DIV_NW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

>>> sv/ictf_back.sv
// filter engine: cordic, gyro increment, blend and output register
module ictf_back #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ictf_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  ictf_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [71:0]       out_data
);
    import ictf_pkg::*;

    localparam int SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [25:0] RND = 26'((64'd1 << SHIFT) >> 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORDIC, ST_MUL, ST_INC_MUL, ST_INC_QD, ST_INC_FIX,
        ST_BL_MUL, ST_BL_GO, ST_BL_WAIT, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [4:0]         cnt_reg;
    logic               seeded_reg;
    logic signed [27:0] cx_reg [2];
    logic signed [27:0] cy_reg [2];
    logic signed [26:0] cz_reg [2];
    logic               zero_reg [2];
    logic signed [15:0] g_reg [2];
    logic [15:0]        dt_reg;
    logic [23:0]        tau_us_reg;
    logic [24:0]        den_reg;
    logic signed [24:0] acc_reg [2];
    logic signed [24:0] prev_reg [2];
    logic signed [24:0] fused_reg [2];
    logic signed [33:0] gprod_reg [2];
    logic [63:0]        iprod_reg [2];
    logic [42:0]        qd_reg [2];
    logic signed [25:0] s_reg [2];
    logic signed [49:0] p1_reg [2];
    logic signed [40:0] p2_reg [2];
    logic               neg_reg [2];
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    logic                div_start;
    logic [DIV_NW-1:0]   div_num [2];
    logic [DIV_DW-1:0]   div_den;
    logic                div_done [2];
    logic [DIV_NW-1:0]   div_quo [2];
    logic signed [24:0]  acc_c [2];
    logic [33:0]         gabs [2];
    logic [42:0]         inc_num [2];
    logic [42:0]         inc_rem [2];
    logic [22:0]         inc_q [2];
    logic signed [23:0]  inc_s [2];
    logic signed [50:0]  bnum [2];
    logic [50:0]         babs [2];
    logic signed [25:0]  qs [2];
    logic [16:0]         o_w [4];

    // per-axis arithmetic: gyro increment fix-up and blend divider operands
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            acc_c[k] = zero_reg[k] ? 25'sd0 : clamp180(28'(cz_reg[k]));
            gabs[k]  = gprod_reg[k][33] ? 34'(-gprod_reg[k]) : 34'(gprod_reg[k]);
            inc_num[k] = 43'({gabs[k][31:0], 10'd0}) + 43'(INC_RND);
            inc_rem[k] = inc_num[k] - qd_reg[k];
            // the reciprocal estimate is low by at most two
            priority if (inc_rem[k] >= 43'(INC_D2))
                inc_q[k] = 23'(iprod_reg[k][63:42]) + 23'd2;
            else if (inc_rem[k] >= 43'(INC_D))
                inc_q[k] = 23'(iprod_reg[k][63:42]) + 23'd1;
            else
                inc_q[k] = 23'(iprod_reg[k][63:42]);
            inc_s[k] = neg_reg[k] ? -$signed({1'b0, inc_q[k]}) : $signed({1'b0, inc_q[k]});
            bnum[k]  = 51'(p1_reg[k]) + 51'(p2_reg[k]);
            babs[k]  = bnum[k][50] ? 51'(-bnum[k]) : 51'(bnum[k]);
            qs[k]    = neg_reg[k] ? -$signed(div_quo[k][25:0])
                                  : $signed(div_quo[k][25:0]);
            div_num[k] = DIV_NW'(babs[k]) + DIV_NW'(den_reg >> 1);
        end
        div_den   = DIV_DW'(den_reg);
        div_start = (state_reg == ST_BL_GO);
    end

    // output rounding to the external angle format
    always_comb
    begin
        o_w[0] = 17'((26'(fused_reg[0]) + RND) >>> SHIFT);
        o_w[1] = 17'((26'(fused_reg[1]) + RND) >>> SHIFT);
        o_w[2] = 17'((26'(acc_reg[0]) + RND) >>> SHIFT);
        o_w[3] = 17'((26'(acc_reg[1]) + RND) >>> SHIFT);
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_div
        ictf_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (div_num[k]),
            .den   (div_den),
            .done  (div_done[k]),
            .quo   (div_quo[k])
        );
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // sequencer with datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            fused_reg[0]  <= '0;
            fused_reg[1]  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // retire the result unless a new one is loaded this cycle
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cx_reg[0]   <= q_item.ax.x;
                        cy_reg[0]   <= q_item.ax.y;
                        cz_reg[0]   <= q_item.ax.z;
                        zero_reg[0] <= q_item.ax.zero;
                        cx_reg[1]   <= q_item.ay.x;
                        cy_reg[1]   <= q_item.ay.y;
                        cz_reg[1]   <= q_item.ay.z;
                        zero_reg[1] <= q_item.ay.zero;
                        g_reg[0]    <= q_item.gx;
                        g_reg[1]    <= q_item.gy;
                        dt_reg      <= q_item.dt;
                        tau_us_reg  <= 24'(cfg.tau_ms) * 24'(US_PER_MS);
                        cnt_reg     <= '0;
                        state_reg   <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        if (cy_reg[k] >= 0)
                        begin
                            cx_reg[k] <= cx_reg[k] + (cy_reg[k] >>> cnt_reg);
                            cy_reg[k] <= cy_reg[k] - (cx_reg[k] >>> cnt_reg);
                            cz_reg[k] <= cz_reg[k] + atan_q16(cnt_reg);
                        end
                        else
                        begin
                            cx_reg[k] <= cx_reg[k] - (cy_reg[k] >>> cnt_reg);
                            cy_reg[k] <= cy_reg[k] + (cx_reg[k] >>> cnt_reg);
                            cz_reg[k] <= cz_reg[k] - atan_q16(cnt_reg);
                        end
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    acc_reg[0]   <= acc_c[0];
                    acc_reg[1]   <= acc_c[1];
                    prev_reg[0]  <= seeded_reg ? fused_reg[0] : acc_c[0];
                    prev_reg[1]  <= seeded_reg ? fused_reg[1] : acc_c[1];
                    gprod_reg[0] <= (17'(g_reg[0]) - 17'(cfg.off_x))
                                    * $signed({1'b0, dt_reg});
                    gprod_reg[1] <= (17'(g_reg[1]) - 17'(cfg.off_y))
                                    * $signed({1'b0, dt_reg});
                    den_reg      <= 25'(tau_us_reg) + 25'(dt_reg);
                    state_reg    <= ST_INC_MUL;
                end
                ST_INC_MUL:
                begin
                    // quotient estimate by reciprocal multiplication
                    for (int k = 0; k < 2; k++)
                    begin
                        iprod_reg[k] <= 64'(gabs[k][31:0]) * 64'(INC_RECIP);
                        neg_reg[k]   <= gprod_reg[k][33];
                    end
                    state_reg <= ST_INC_QD;
                end
                ST_INC_QD:
                begin
                    for (int k = 0; k < 2; k++)
                        qd_reg[k] <= 43'(iprod_reg[k][63:42]) * 43'(INC_D);
                    state_reg <= ST_INC_FIX;
                end
                ST_INC_FIX:
                begin
                    s_reg[0]  <= 26'(prev_reg[0]) + 26'(inc_s[0]);
                    s_reg[1]  <= 26'(prev_reg[1]) + 26'(inc_s[1]);
                    state_reg <= ST_BL_MUL;
                end
                ST_BL_MUL:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        p1_reg[k] <= 50'($signed({1'b0, tau_us_reg}) * s_reg[k]);
                        p2_reg[k] <= 41'($signed({1'b0, dt_reg}) * acc_reg[k]);
                    end
                    // zero time constant and zero step: plain gyro integration
                    if (den_reg == 25'd0)
                    begin
                        fused_reg[0] <= clamp180(28'(s_reg[0]));
                        fused_reg[1] <= clamp180(28'(s_reg[1]));
                        seeded_reg   <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                    else
                        state_reg <= ST_BL_GO;
                end
                ST_BL_GO:
                begin
                    neg_reg[0] <= bnum[0][50];
                    neg_reg[1] <= bnum[1][50];
                    state_reg  <= ST_BL_WAIT;
                end
                ST_BL_WAIT:
                begin
                    if (div_done[0])
                    begin
                        fused_reg[0] <= clamp180(28'(qs[0]));
                        fused_reg[1] <= clamp180(28'(qs[1]));
                        seeded_reg   <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg  <= {4'd0, o_w[3], o_w[2], o_w[1], o_w[0]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/imu_tilt_complementary_filter_top.sv
// top level of the accelerometer and gyro tilt complementary filter
// the engine works on one item at a time and finishes it before it pops the next one;
// its pace is set by the iterative cordic and the bit-serial blend dividers, and a zero
// blend denominator skips the dividers
// a two-entry queue takes new items while the engine works or a result waits
// reset (rst_n low, asynchronous): control and configuration registers return to defaults, filter unseeded
module imu_tilt_complementary_filter_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, step_time_us
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fused_angle_x, fused_angle_y, accel_angle_x, accel_angle_y, zero pad
    output logic [71:0] m_axis_tdata
);
    import ictf_pkg::*;

    localparam logic [1:0] REG_TAU   = 2'd0;
    localparam logic [1:0] REG_OFF_X = 2'd1;
    localparam logic [1:0] REG_OFF_Y = 2'd2;

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   q_item;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tau_ms <= 14'd500;
            cfg_reg.off_x  <= 16'sd424;
            cfg_reg.off_y  <= 16'sd134;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAU:   cfg_reg.tau_ms <= cfg_data[13:0];
                REG_OFF_X: cfg_reg.off_x  <= $signed(cfg_data);
                REG_OFF_Y: cfg_reg.off_y  <= $signed(cfg_data);
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

    ictf_front u_front (
        .tdata (s_axis_tdata),
        .item  (front_item)
    );

    ictf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    ictf_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (!q_stat.empty),
        .q_item    (q_item),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    // queue cannot be both empty and full
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue status inconsistent");

    // engine only pops a filled queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a pop without a push frees a slot for the next cycle
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> !q_stat.full)
        else $error("queue still full after pop");
`endif

endmodule

>>> verif/tilt_filter_checker.sv
// checker: predicts the fused and accelerometer tilt angles and compares results
`timescale 1ns / 100ps

module tilt_filter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [1:0] REG_TAU   = 2'd0;
    localparam logic [1:0] REG_OFF_X = 2'd1;
    localparam logic [1:0] REG_OFF_Y = 2'd2;
    localparam longint ANG180 = 64'sd11796480;

    typedef struct packed {
        logic [16:0] fused_x;
        logic [16:0] fused_y;
        logic [16:0] acc_x;
        logic [16:0] acc_y;
    } angles_t;

    angles_t expected_angles[$];

    longint tau_ms, bias_x, bias_y, est_x, est_y;
    bit     est_valid;

    function automatic longint sat180(input longint v);
        if (v > ANG180) return ANG180;
        if (v < -ANG180) return -ANG180;
        return v;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // vectoring cordic atan2 in degrees * 2^16
    function automatic longint tilt_atan2(input longint yi, input longint xi);
        longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};
        longint x, y, z, t, dx, dy;
        if (xi == 0 && yi == 0) return 0;
        x = xi * 256;
        y = yi * 256;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                z = ANG180 / 2; t = x; x = y; y = -t;
            end
            else
            begin
                z = -ANG180 / 2; t = x; x = -y; y = t;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return sat180(z);
    endfunction

    function automatic logic [16:0] to_deg8(input longint q16);
        longint v;
        v = (q16 + 128) >>> 8;
        return v[16:0];
    endfunction

    function automatic longint fuse_axis(input longint prev, input longint rate,
                                         input longint bias, input longint dt,
                                         input longint acc);
        longint tau_us, inc, den;
        tau_us = tau_ms * 1000;
        inc = round_div((rate - bias) * dt * 65536, 64'd131000000);
        den = tau_us + dt;
        if (den == 0) return sat180(prev + inc);
        return sat180(round_div(tau_us * (prev + inc) + dt * acc, den));
    endfunction

    // register writes, accepted inputs and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        longint ax, ay, az, gx, gy, dt, acc_x, acc_y;
        angles_t exp_a, got_a;
        if (!rst_n)
        begin
            tau_ms = 500; bias_x = 424; bias_y = 134;
            est_valid = 0; est_x = 0; est_y = 0;
            expected_angles.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TAU:   tau_ms = cfg_data[13:0];
                    REG_OFF_X: bias_x = $signed(cfg_data);
                    REG_OFF_Y: bias_y = $signed(cfg_data);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_a.fused_x = m_axis_tdata[16:0];
                got_a.fused_y = m_axis_tdata[33:17];
                got_a.acc_x   = m_axis_tdata[50:34];
                got_a.acc_y   = m_axis_tdata[67:51];
                if (expected_angles.size() == 0)
                begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_a = expected_angles.pop_front();
                    if (got_a.fused_x !== exp_a.fused_x)
                    begin
                        $error("fused_angle_x expected %h actual %h",
                               exp_a.fused_x, got_a.fused_x);
                        fail_count++;
                    end
                    if (got_a.fused_y !== exp_a.fused_y)
                    begin
                        $error("fused_angle_y expected %h actual %h",
                               exp_a.fused_y, got_a.fused_y);
                        fail_count++;
                    end
                    if (got_a.acc_x !== exp_a.acc_x)
                    begin
                        $error("accel_angle_x expected %h actual %h",
                               exp_a.acc_x, got_a.acc_x);
                        fail_count++;
                    end
                    if (got_a.acc_y !== exp_a.acc_y)
                    begin
                        $error("accel_angle_y expected %h actual %h",
                               exp_a.acc_y, got_a.acc_y);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                ax = $signed(s_axis_tdata[15:0]);
                ay = $signed(s_axis_tdata[31:16]);
                az = $signed(s_axis_tdata[47:32]);
                gx = $signed(s_axis_tdata[63:48]);
                gy = $signed(s_axis_tdata[79:64]);
                dt = s_axis_tdata[95:80];
                acc_x = tilt_atan2(ay, az);
                acc_y = tilt_atan2(-ax, az);
                if (!est_valid)
                begin
                    est_x = acc_x; est_y = acc_y; est_valid = 1;
                end
                est_x = fuse_axis(est_x, gx, bias_x, dt, acc_x);
                est_y = fuse_axis(est_y, gy, bias_y, dt, acc_y);
                exp_a.fused_x = to_deg8(est_x);
                exp_a.fused_y = to_deg8(est_y);
                exp_a.acc_x   = to_deg8(acc_x);
                exp_a.acc_y   = to_deg8(acc_y);
                expected_angles.push_back(exp_a);
            end
            pending_count = expected_angles.size();
        end
    end

endmodule

>>> verif/tb_imu_tilt_complementary_filter_top.sv
// testbench top: drives samples and register writes, gives the verdict
`timescale 1ns / 100ps

module tb_imu_tilt_complementary_filter_top;

    localparam logic [1:0] REG_TAU   = 2'd0;
    localparam logic [1:0] REG_OFF_X = 2'd1;
    localparam logic [1:0] REG_OFF_Y = 2'd2;
    localparam logic [1:0] REG_NONE  = 2'd3;
    localparam int DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    int          fail_count, pending_count;
    longint      cycle_count = 0;

    imu_tilt_complementary_filter_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    tilt_filter_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side stalls
    initial
    begin
        int stall;
        bit calm;
        forever
        begin
            @(posedge clk);
            calm = ($urandom_range(0, 9) == 0);
            stall = calm ? 0 : gap_len();
            m_axis_tready <= (stall == 0);
            repeat (stall) @(posedge clk);
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // first lets the checker count the last transaction, then waits for no pending result
    task automatic wait_idle();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] gx,
                               input logic [15:0] gy, input logic [15:0] dt,
                               input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {dt, gy, gx, az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // mostly small or moderate step times, full range now and then
    function automatic logic [15:0] pick_dt();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom_range(0, 5000));
        if (r < 8) return 16'($urandom_range(0, 65535));
        return (r == 8) ? 16'd0 : 16'hFFFF;
    endfunction

    function automatic logic [15:0] pick_raw();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r == 2) return 16'h0000;
        if (r < 5) return 16'($urandom_range(0, 40)) - 16'd20;
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int phase;
        bit gaps;
        logic [15:0] tau_set[6] = '{16'd500, 16'd1, 16'd10000, 16'd0, 16'd16383, 16'd50};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero operands, each quadrant
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 0);
        send_sample(16'd0, 16'd100, 16'hFF00, 16'h7FFF, 16'h8000, 16'hFFFF, 0);
        send_sample(16'd0, 16'hFF00, 16'hFF00, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'd424, 16'd134, 16'd0, 0);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 16'd1, 0);
        send_sample(16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd2000, 0);
        send_sample(16'd0, 16'd1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
        send_sample(16'd0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 0);
        send_sample(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 0);
        send_sample(16'hC000, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd500, 0);
        s_axis_tvalid <= 0;
        wait_idle();

        // zero time constant with zero and nonzero step times, plus ignored index
        write_reg(REG_TAU, 16'd0);
        write_reg(REG_NONE, 16'hFFFF);
        send_sample(16'd100, 16'd200, 16'd16000, 16'h7FFF, 16'h8000, 16'd0, 0);
        send_sample(16'd100, 16'd200, 16'd16000, 16'h7FFF, 16'h8000, 16'd0, 0);
        send_sample(16'd100, 16'd200, 16'd16000, 16'd0, 16'd0, 16'd10, 0);
        s_axis_tvalid <= 0;
        wait_idle();

        // random phases across register settings
        for (phase = 0; phase < 12; phase++)
        begin
            write_reg(REG_TAU, tau_set[phase % 6]);
            write_reg(REG_OFF_X, (phase == 1) ? 16'h8000 : (phase == 2) ? 16'h7FFF
                                 : 16'($urandom_range(0, 65535)));
            write_reg(REG_OFF_Y, (phase == 1) ? 16'h7FFF : (phase == 2) ? 16'h8000
                                 : 16'($urandom_range(0, 65535)));
            gaps = (phase % 4 != 3);
            repeat (155)
                send_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                            pick_dt(), gaps);
            s_axis_tvalid <= 0;
            wait_idle();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
